FILE: design/itda_pkg.sv
`default_nettype none

package itda_pkg;

    localparam int NUM_DIGITS   = 10;
    localparam int DIGIT_IDX_W  = $clog2(NUM_DIGITS);
    localparam int PASS_BITS    = 4;
    localparam int WORD_W       = 32;
    localparam int PASSES       = WORD_W / PASS_BITS;
    localparam int PASS_CNT_W   = $clog2(PASSES);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] DIGIT_BASE = 8'd48;
    localparam logic [7:0] MINUS_CODE = 8'd45;

    typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

    typedef struct packed {
        bcd_t                   bcd;
        logic                   negative;
        logic [DIGIT_IDX_W-1:0] top_index;
        logic [3:0]             text_length;
    } text_rec_t;

endpackage

`default_nettype wire

FILE: design/itda_if.sv
`default_nettype none

interface itda_num_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        signed_mode;

    modport source (output valid, output value, output signed_mode, input ready);
    modport sink   (input valid, input value, input signed_mode, output ready);
endinterface

interface itda_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;
    logic [3:0] text_length;

    modport source (output valid, output char_code, output is_last, output text_length,
                    input ready);
    modport sink   (input valid, input char_code, input is_last, input text_length,
                    output ready);
endinterface

`default_nettype wire

FILE: design/itda_front.sv
`default_nettype none

module itda_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    itda_num_if.sink               num,
    output logic                   wr_valid,
    input  wire logic              wr_ready,
    output itda_pkg::text_rec_t    wr_data
);
    import itda_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_CONV = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [PASS_CNT_W-1:0]  pass_reg, pass_next;
    logic [WORD_W-1:0]      mag_reg, mag_next;
    bcd_t                   bcd_reg, bcd_next;
    logic                   neg_reg, neg_next;

    bcd_t                   bcd_step;
    logic [WORD_W-1:0]      mag_step;
    logic [DIGIT_IDX_W-1:0] top_idx;
    logic                   in_neg;

    assign num.ready = (state_reg == F_IDLE);
    assign in_neg    = num.signed_mode & num.value[WORD_W-1];

    // four shift-add-3 steps per cycle
    always_comb
    begin
        bcd_step = bcd_reg;
        mag_step = mag_reg;
        for (int s = 0; s < PASS_BITS; s++)
        begin
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                if (bcd_step[d] >= 4'd5)
                begin
                    bcd_step[d] = bcd_step[d] + 4'd3;
                end
            end
            bcd_step = {bcd_step[NUM_DIGITS-1][2:0], bcd_step[NUM_DIGITS-2:0],
                        mag_step[WORD_W-1]};
            mag_step = {mag_step[WORD_W-2:0], 1'b0};
        end
    end

    always_comb
    begin
        top_idx = '0;
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (bcd_reg[d] != 4'd0)
            begin
                top_idx = DIGIT_IDX_W'(d);
            end
        end
    end

    assign wr_valid              = (state_reg == F_PUSH);
    assign wr_data.bcd           = bcd_reg;
    assign wr_data.negative      = neg_reg;
    assign wr_data.top_index     = top_idx;
    assign wr_data.text_length   = 4'(top_idx) + 4'd1 + {3'd0, neg_reg};

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (num.valid)
                begin
                    neg_next   = in_neg;
                    mag_next   = in_neg ? (~num.value + 32'd1) : num.value;
                    bcd_next   = '0;
                    pass_next  = '0;
                    state_next = F_CONV;
                end
            end
            F_CONV:
            begin
                bcd_next  = bcd_step;
                mag_next  = mag_step;
                pass_next = pass_reg + 1'b1;
                if (pass_reg == PASS_CNT_W'(PASSES - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (wr_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            pass_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

endmodule

`default_nettype wire

FILE: design/itda_queue.sv
`default_nettype none

module itda_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    input  wire itda_pkg::text_rec_t wr_data,
    output logic                   rd_valid,
    input  wire logic              rd_ready,
    output itda_pkg::text_rec_t    rd_data
);
    import itda_pkg::*;

    text_rec_t              slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wptr_reg, rptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_wr, do_rd;

    assign wr_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rptr_reg];
    assign do_wr    = wr_valid & wr_ready;
    assign do_rd    = rd_valid & rd_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr & ~do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd & ~do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: design/itda_back.sv
`default_nettype none

module itda_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_valid,
    output logic                   rd_ready,
    input  wire itda_pkg::text_rec_t rd_data,
    itda_char_if.source            txt
);
    import itda_pkg::*;

    logic                   busy_reg;
    logic                   minus_reg;
    logic [DIGIT_IDX_W-1:0] pos_reg;
    bcd_t                   bcd_reg;
    logic [3:0]             len_reg;
    logic                   last_char;
    logic                   sent;

    assign rd_ready        = ~busy_reg;
    assign last_char       = ~minus_reg & (pos_reg == '0);
    assign sent            = txt.valid & txt.ready;

    assign txt.valid       = busy_reg;
    assign txt.char_code   = minus_reg ? MINUS_CODE : (DIGIT_BASE + {4'd0, bcd_reg[pos_reg]});
    assign txt.is_last     = last_char;
    assign txt.text_length = len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            minus_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else if (!busy_reg)
        begin
            if (rd_valid)
            begin
                busy_reg  <= 1'b1;
                minus_reg <= rd_data.negative;
                pos_reg   <= rd_data.top_index;
            end
        end
        else if (sent)
        begin
            if (last_char)
            begin
                busy_reg <= 1'b0;
            end
            else if (minus_reg)
            begin
                minus_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && rd_valid)
        begin
            bcd_reg <= rd_data.bcd;
            len_reg <= rd_data.text_length;
        end
    end

endmodule

`default_nettype wire

FILE: design/integer_to_decimal_ascii_top.sv
`default_nettype none

// Prints a 32-bit word, read as signed or unsigned, as decimal ASCII text:
// one character word per output transfer, most significant first, with a
// leading '-' for negative signed values and no leading zeros. Every
// character carries the total text length and the final one is flagged.
// The front end takes a number while idle, converts it to BCD with a
// shift-add-3 unit handling four bits per cycle, then hands the result to
// a two-entry queue; it accepts a new number only after that hand-off.
// The back end loads a queued entry while idle and sends one character
// per cycle while the receiver is ready; it loads the next entry only
// after the last character of the current number has been sent.
module integer_to_decimal_ascii_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    itda_num_if.sink    num,
    itda_char_if.source txt
);
    import itda_pkg::*;

    logic      wr_valid, wr_ready, rd_valid, rd_ready;
    text_rec_t wr_data, rd_data;

    itda_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .num      (num),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr_data  (wr_data)
    );

    itda_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (wr_valid),
        .wr_ready (wr_ready),
        .wr_data  (wr_data),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd_data  (rd_data)
    );

    itda_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd_data  (rd_data),
        .txt      (txt)
    );

endmodule

`default_nettype wire

FILE: design/itda_checker.sv
`default_nettype none

module itda_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       txt_valid,
    input wire logic       txt_ready,
    input wire logic [7:0] txt_char_code,
    input wire logic       txt_is_last,
    input wire logic [3:0] txt_text_length
);
    import itda_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        txt_valid && !txt_ready |=> txt_valid)
        else $error("char word dropped while stalled");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        txt_valid |-> (txt_char_code == MINUS_CODE) ||
                      (txt_char_code >= DIGIT_BASE && txt_char_code <= DIGIT_BASE + 8'd9))
        else $error("char code outside minus and digits");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        txt_valid |-> (txt_text_length >= 4'd1 && txt_text_length <= 4'd11))
        else $error("text length out of range");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        txt_valid && (txt_char_code == MINUS_CODE) |-> !txt_is_last)
        else $error("minus sign ends a number");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        txt_valid && txt_ready && !txt_is_last |=>
            txt_valid && $stable(txt_text_length))
        else $error("character run broken");

endmodule

bind integer_to_decimal_ascii_top itda_checker u_itda_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .txt_valid       (txt.valid),
    .txt_ready       (txt.ready),
    .txt_char_code   (txt.char_code),
    .txt_is_last     (txt.is_last),
    .txt_text_length (txt.text_length)
);

`default_nettype wire
